// ===== rtl/fftr2_pkg.sv =====
// ----------------------------------------------------------------------------
// fftr2_pkg
// Shared types, constants, twiddle tables and arithmetic helpers of the
// radix-2 decimation-in-frequency transform block.
// ----------------------------------------------------------------------------
package fftr2_pkg;

    localparam int LOG2_MAX_POINTS       = 10;
    localparam int TWIDDLE_FRACTION_BITS = 15;
    localparam int DEPTH    = 1 << LOG2_MAX_POINTS;
    localparam int QTR      = DEPTH / 4;
    localparam int ADDR_W   = LOG2_MAX_POINTS;
    localparam int BFLY_W   = LOG2_MAX_POINTS - 1;
    localparam int QIDX_W   = LOG2_MAX_POINTS - 1;
    localparam int LOG_W    = 4;
    localparam int DATA_W   = 28;
    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 2 * DATA_W;
    localparam int TW_W     = TWIDDLE_FRACTION_BITS + 2;
    localparam int DIFF_W   = DATA_W + 1;
    localparam int PROD_W   = DIFF_W + TW_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int SAT_W    = ACC_W + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_POINTS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = CFG_IDX_W'(1);

    localparam longint unsigned PI_Q44 = 64'h3243F6A8885A;

    typedef enum logic [1:0] {
        STATUS_LOADED = 2'd0,
        STATUS_BIN    = 2'd1,
        STATUS_SEQ    = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_OUT, ST_RA, ST_RB, ST_SUM,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_WR
    } state_t;

    typedef logic signed [TW_W-1:0] tw_rom_t [0:QTR];

    function automatic longint unsigned to_fraction(input longint signed q30);
        longint signed v;
        begin
            v = q30;
            if (v < 0) v = 0;
            if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
            if (TWIDDLE_FRACTION_BITS >= 30) return longint'(v);
            return (longint'(v) + (64'd1 << (29 - TWIDDLE_FRACTION_BITS)))
                   >> (30 - TWIDDLE_FRACTION_BITS);
        end
    endfunction

    // Restoring long division, used only while the twiddle tables are built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q, rem;
        begin
            q   = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[b] = 1'b1;
                end
            end
            return q;
        end
    endfunction

    function automatic tw_rom_t build_rom(input bit want_sin);
        tw_rom_t rom;
        longint unsigned t, t2, term, r;
        longint signed acc;
        int sh;
        begin
            sh = 13 + LOG2_MAX_POINTS;
            for (int u = 0; u <= QTR; u++) begin
                t  = (PI_Q44 * longint'(u) + (64'd1 << (sh - 1))) >> sh;
                t2 = (t * t + (64'd1 << 29)) >> 30;
                if (want_sin) begin
                    term = t;
                    acc  = longint'(t);
                    for (int i = 1; i <= 12; i++) begin
                        term = div_u64((term * t2 + (64'd1 << 29)) >> 30,
                                       longint'((2 * i) * (2 * i + 1)));
                        acc = ((i & 1) == 1) ? acc - longint'(term) : acc + longint'(term);
                    end
                end else begin
                    term = 64'd1 << 30;
                    acc  = longint'(term);
                    for (int i = 1; i <= 12; i++) begin
                        term = div_u64((term * t2 + (64'd1 << 29)) >> 30,
                                       longint'((2 * i - 1) * (2 * i)));
                        acc = ((i & 1) == 1) ? acc - longint'(term) : acc + longint'(term);
                    end
                end
                r = to_fraction(acc);
                rom[u] = TW_W'(r);
            end
            return rom;
        end
    endfunction

    localparam tw_rom_t COS_ROM = build_rom(1'b0);
    localparam tw_rom_t SIN_ROM = build_rom(1'b1);

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
        begin
            if (&v[SAT_W-1:DATA_W-1] || ~|v[SAT_W-1:DATA_W-1]) return v[DATA_W-1:0];
            return v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] ax;
        logic [ACC_W:0] mag;
        logic [ACC_W:0] r;
        logic signed [SAT_W-1:0] v;
        begin
            ax  = {a[ACC_W-1], a};
            mag = a[ACC_W-1] ? -ax : ax;
            r   = (mag + ((ACC_W+1)'(1) << (TWIDDLE_FRACTION_BITS - 1)))
                  >> TWIDDLE_FRACTION_BITS;
            v   = SAT_W'(r);
            if (a[ACC_W-1]) v = -v;
            return sat_data(v);
        end
    endfunction

endpackage

// ===== rtl/fftr2_if.sv =====
// ----------------------------------------------------------------------------
// fftr2 channel interfaces
// Valid/ready channels for sample and read commands, bins, and register writes.
// ----------------------------------------------------------------------------
interface fftr2_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    modport source (output valid, func, sample_re, sample_im, input ready);
    modport sink   (input valid, func, sample_re, sample_im, output ready);
endinterface

interface fftr2_out_if;
    logic        valid;
    logic        ready;
    logic signed [27:0] result_re;
    logic signed [27:0] result_im;
    logic        last;
    logic [1:0]  status;
    modport source (output valid, result_re, result_im, last, status, input ready);
    modport sink   (input valid, result_re, result_im, last, status, output ready);
endinterface

interface fftr2_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fftr2_bank.sv =====
// ----------------------------------------------------------------------------
// fftr2_bank
// One data bank: single write port, one registered read port.
// ----------------------------------------------------------------------------
module fftr2_bank (
    input  logic                          clk,
    input  logic                          we,
    input  logic [fftr2_pkg::ADDR_W-1:0]  waddr,
    input  logic [fftr2_pkg::WORD_W-1:0]  wdata,
    input  logic [fftr2_pkg::ADDR_W-1:0]  raddr,
    output logic [fftr2_pkg::WORD_W-1:0]  rdata
);
    import fftr2_pkg::*;

    logic [WORD_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fft_radix2_dif_autosort_top.sv =====
// ----------------------------------------------------------------------------
// fft_radix2_dif_autosort_top
// Self-sorting radix-2 DIF transform with one shared butterfly datapath.
//
//   channel   dir  words
//   in_ch     in   func, sample_re, sample_im
//   out_ch    out  result_re, result_im, last, status
//   cfg_ch    in   index, data
//
// A load or an out-of-sequence word sets its result word as it is taken; a
// read word first passes through ST_OUT, which registers the bin from the bank.
// The last load starts the transform: each butterfly steps through ST_RA, ST_RB,
// ST_SUM, ST_M0 to ST_M4 and ST_WR, sharing the single multiplier and bank ports.
// Reset leaves the block loading with 1024 points, forward mode.
// A waiting result word holds off the next input word.
// ----------------------------------------------------------------------------
module fft_radix2_dif_autosort_top (
    input  logic clk,
    input  logic rst_n,
    fftr2_in_if.sink    in_ch,
    fftr2_out_if.source out_ch,
    fftr2_cfg_if.sink   cfg_ch
);
    import fftr2_pkg::*;

    state_t state_reg, state_next;
    logic              phase_reg;
    logic [ADDR_W-1:0] load_cnt_reg;
    logic [ADDR_W-1:0] read_cnt_reg;
    logic [LOG_W-1:0]  stage_reg;
    logic [BFLY_W-1:0] bfly_reg;
    logic [LOG_W-1:0]  log2_reg;
    logic              inv_reg;
    logic              out_valid_reg;
    logic signed [DATA_W-1:0] out_re_reg, out_im_reg;
    logic              out_last_reg;
    status_t           out_status_reg;

    logic [WORD_W-1:0] a_reg;
    logic signed [TW_W-1:0]   c_reg, s_reg;
    logic signed [DIFF_W-1:0] dr_reg, di_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] res_re_reg;

    logic [WORD_W-1:0] rdata_a, rdata_b, rsrc, rres;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en_a, wr_en_b;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [TW_W-1:0]   mul_b;

    logic              in_acc, cfg_acc, dst_is_a, last_bfly, last_stage;
    logic [ADDR_W-1:0] nmask, half_n, hmask, s2, i1, i2, tw_full;
    logic [QIDX_W-1:0] tw_idx;
    logic signed [DATA_W-1:0] ar, ai, br, bi, rre, rim;
    logic signed [DATA_W:0]   nim;
    logic signed [DATA_W-1:0] sh_re, sh_im;
    logic signed [DATA_W-1:0] ld_re, ld_im;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign nmask  = ADDR_W'((1 << log2_reg) - 1);
    assign half_n = ADDR_W'(1 << (log2_reg - 1));
    assign hmask  = ADDR_W'((1 << (stage_reg - 1)) - 1);
    assign s2     = {1'b0, bfly_reg} | half_n;
    assign i1     = ((({1'b0, bfly_reg} >> (stage_reg - 1)) << stage_reg)
                    | ({1'b0, bfly_reg} & hmask));
    assign i2     = i1 | ADDR_W'(1 << (stage_reg - 1));
    assign tw_full = ({1'b0, bfly_reg} & ~hmask) << (LOG_W'(LOG2_MAX_POINTS) - log2_reg);
    assign tw_idx  = tw_full[QIDX_W-1:0];

    assign last_bfly  = ({1'b0, bfly_reg} == (half_n - ADDR_W'(1)));
    assign last_stage = (stage_reg == log2_reg);
    assign dst_is_a   = ~stage_reg[0];
    assign rsrc = stage_reg[0] ? rdata_a : rdata_b;
    assign rres = log2_reg[0] ? rdata_b : rdata_a;

    assign ar = a_reg[WORD_W-1:DATA_W];
    assign ai = a_reg[DATA_W-1:0];
    assign br = rsrc[WORD_W-1:DATA_W];
    assign bi = rsrc[DATA_W-1:0];
    assign rre = rres[WORD_W-1:DATA_W];
    assign rim = rres[DATA_W-1:0];
    assign nim = -{rim[DATA_W-1], rim};
    assign sh_re = rre >>> log2_reg;
    assign sh_im = DATA_W'(nim >>> log2_reg);
    assign ld_re = DATA_W'(in_ch.sample_re);
    assign ld_im = inv_reg ? DATA_W'(-(DATA_W'(in_ch.sample_im))) : DATA_W'(in_ch.sample_im);

    fftr2_bank u_bank_a (
        .clk   (clk),
        .we    (wr_en_a),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    fftr2_bank u_bank_b (
        .clk   (clk),
        .we    (wr_en_b),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        in_ch.ready = 1'b0;
        rd_addr = {1'b0, bfly_reg};
        wr_en_a = 1'b0;
        wr_en_b = 1'b0;
        wr_addr = i1;
        wr_data = {sat_data(SAT_W'(ar) + SAT_W'(br)), sat_data(SAT_W'(ai) + SAT_W'(bi))};
        mul_a = dr_reg;
        mul_b = c_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !out_valid_reg;
                rd_addr = read_cnt_reg;
                if (in_acc && !in_ch.func && !phase_reg)
                begin
                    wr_en_a = 1'b1;
                    wr_addr = load_cnt_reg;
                    wr_data = {ld_re, ld_im};
                    if (load_cnt_reg == nmask)
                    begin
                        state_next = ST_RA;
                    end
                end
                else if (in_acc && in_ch.func && phase_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: state_next = ST_IDLE;
            ST_RA:  state_next = ST_RB;
            ST_RB:
            begin
                rd_addr = s2;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                wr_en_a = dst_is_a;
                wr_en_b = !dst_is_a;
                state_next = ST_M0;
            end
            ST_M0: state_next = ST_M1;
            ST_M1:
            begin
                mul_a = di_reg;
                mul_b = s_reg;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                mul_a = di_reg;
                mul_b = c_reg;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                mul_a = dr_reg;
                mul_b = s_reg;
                state_next = ST_M4;
            end
            ST_M4: state_next = ST_WR;
            ST_WR:
            begin
                wr_en_a = dst_is_a;
                wr_en_b = !dst_is_a;
                wr_addr = i2;
                wr_data = {res_re_reg, round_sat(acc_reg)};
                state_next = (last_bfly && last_stage) ? ST_IDLE : ST_RA;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            load_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            stage_reg     <= LOG_W'(1);
            bfly_reg      <= '0;
            log2_reg      <= LOG_W'(LOG2_MAX_POINTS);
            inv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_acc && (cfg_ch.index == CFG_LOG2_POINTS
                            || cfg_ch.index == CFG_INVERSE_MODE))
            begin
                if (cfg_ch.index == CFG_LOG2_POINTS)
                begin
                    if (cfg_ch.data == '0)
                        log2_reg <= LOG_W'(1);
                    else if (cfg_ch.data > LOG_W'(LOG2_MAX_POINTS))
                        log2_reg <= LOG_W'(LOG2_MAX_POINTS);
                    else
                        log2_reg <= cfg_ch.data;
                end
                else
                begin
                    inv_reg <= cfg_ch.data[0];
                end
                phase_reg    <= 1'b0;
                load_cnt_reg <= '0;
                read_cnt_reg <= '0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (!in_ch.func && !phase_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            load_cnt_reg  <= load_cnt_reg + ADDR_W'(1);
                            stage_reg     <= LOG_W'(1);
                            bfly_reg      <= '0;
                        end
                        else if (in_ch.func && phase_reg)
                        begin
                            read_cnt_reg <= read_cnt_reg + ADDR_W'(1);
                            if (read_cnt_reg == nmask)
                            begin
                                phase_reg    <= 1'b0;
                                load_cnt_reg <= '0;
                                read_cnt_reg <= '0;
                            end
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT: out_valid_reg <= 1'b1;
                ST_WR:
                begin
                    if (last_bfly)
                    begin
                        bfly_reg  <= '0;
                        stage_reg <= stage_reg + LOG_W'(1);
                        if (last_stage)
                        begin
                            phase_reg    <= 1'b1;
                            read_cnt_reg <= '0;
                        end
                    end
                    else
                    begin
                        bfly_reg <= bfly_reg + BFLY_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    out_re_reg     <= '0;
                    out_im_reg     <= '0;
                    out_last_reg   <= 1'b0;
                    out_status_reg <= STATUS_SEQ;
                    if (!in_ch.func && !phase_reg)
                        out_status_reg <= STATUS_LOADED;
                    else if (in_ch.func && phase_reg)
                    begin
                        out_status_reg <= STATUS_BIN;
                        out_last_reg   <= (read_cnt_reg == nmask);
                    end
                end
            end
            ST_OUT:
            begin
                out_re_reg <= inv_reg ? sh_re : rre;
                out_im_reg <= inv_reg ? sh_im : rim;
            end
            ST_RA:
            begin
                if (tw_full <= ADDR_W'(QTR))
                begin
                    c_reg <= COS_ROM[tw_idx];
                    s_reg <= SIN_ROM[tw_idx];
                end
                else
                begin
                    c_reg <= -COS_ROM[QIDX_W'(ADDR_W'(DEPTH / 2) - tw_full)];
                    s_reg <= SIN_ROM[QIDX_W'(ADDR_W'(DEPTH / 2) - tw_full)];
                end
            end
            ST_RB: a_reg <= rsrc;
            ST_SUM:
            begin
                dr_reg <= DIFF_W'(ar) - DIFF_W'(br);
                di_reg <= DIFF_W'(ai) - DIFF_W'(bi);
            end
            ST_M1: acc_reg <= ACC_W'(prod_reg);
            ST_M2: acc_reg <= acc_reg + ACC_W'(prod_reg);
            ST_M3:
            begin
                res_re_reg <= round_sat(acc_reg);
                acc_reg    <= ACC_W'(prod_reg);
            end
            ST_M4: acc_reg <= acc_reg - ACC_W'(prod_reg);
            default: ;
        endcase
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.result_re = out_re_reg;
    assign out_ch.result_im = out_im_reg;
    assign out_ch.last      = out_last_reg;
    assign out_ch.status    = out_status_reg;

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("Input word taken while the datapath is busy.");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM || state_reg == ST_WR)
        |-> (stage_reg >= LOG_W'(1) && stage_reg <= log2_reg))
        else $error("Butterfly stage out of range.");

    a_done_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR && last_bfly && last_stage) |=> phase_reg)
        else $error("Transform finished without entering the read phase.");

    a_load_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !in_ch.func && !phase_reg)
        |=> (out_valid_reg && out_status_reg == STATUS_LOADED))
        else $error("Load word produced no acknowledge.");

endmodule

// ===== sim/fftr2_checker.sv =====
// ----------------------------------------------------------------------------
// fftr2_checker
// Watches the sample, bin and register channels of the transform block. It
// keeps its own copy of the banks, counters and settings, predicts every
// result word and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module fftr2_checker
    import fftr2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fftr2_in_if  in_ch,
    fftr2_out_if out_ch,
    fftr2_cfg_if cfg_ch,
    output int   fails,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     last;
        status_t                  status;
    } bin_word_t;

    typedef struct {
        longint re;
        longint im;
    } point_t;

    bin_word_t bins_due[$];
    point_t    bank[2][DEPTH];
    longint    cos_tab[QTR+1];
    longint    sin_tab[QTR+1];
    int        out_bank;
    int        n_log;
    bit        inv;
    int        loaded;
    int        readout;
    bit        reading;

    function automatic longint q30_to_frac(longint v);
        if (v < 0) v = 0;
        if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
        return (v + (64'sd1 <<< (29 - TWIDDLE_FRACTION_BITS))) >>> (30 - TWIDDLE_FRACTION_BITS);
    endfunction

    task automatic make_twiddles();
        longint unsigned ang, ang2, tc, ts;
        longint c, s;
        int sh;
        sh = 13 + LOG2_MAX_POINTS;
        for (int u = 0; u <= QTR; u++)
        begin
            ang  = (PI_Q44 * longint'(u) + (64'd1 << (sh - 1))) >> sh;
            ang2 = (ang * ang + (64'd1 << 29)) >> 30;
            tc = 64'd1 << 30;
            c  = longint'(tc);
            ts = ang;
            s  = longint'(ts);
            for (int i = 1; i <= 12; i++)
            begin
                tc = ((tc * ang2 + (64'd1 << 29)) >> 30) / longint'((2*i - 1) * (2*i));
                ts = ((ts * ang2 + (64'd1 << 29)) >> 30) / longint'((2*i) * (2*i + 1));
                c  = (i % 2 == 1) ? c - longint'(tc) : c + longint'(tc);
                s  = (i % 2 == 1) ? s - longint'(ts) : s + longint'(ts);
            end
            cos_tab[u] = q30_to_frac(c);
            sin_tab[u] = q30_to_frac(s);
        end
    endtask

    function automatic longint clip28(longint v);
        if (v > 134217727) return 134217727;
        if (v < -134217728) return -134217728;
        return v;
    endfunction

    function automatic longint round_frac(longint p);
        longint h;
        h = 64'sd1 <<< (TWIDDLE_FRACTION_BITS - 1);
        if (p >= 0) return (p + h) >>> TWIDDLE_FRACTION_BITS;
        return -((-p + h) >>> TWIDDLE_FRACTION_BITS);
    endfunction

    task automatic run_stages();
        int npts, half, blocks, tw, src, dst, i1, i2, s1, s2;
        longint c, s, ar, ai, br, bi, dr, di;
        npts = 1 << n_log;
        src = 0;
        dst = 1;
        for (int k = 1; k <= n_log; k++)
        begin
            half = 1 << (k - 1);
            blocks = npts >> k;
            for (int j = 0; j < blocks; j++)
            begin
                tw = (j << (k - 1)) << (LOG2_MAX_POINTS - n_log);
                if (tw <= QTR)
                begin
                    c = cos_tab[tw];
                    s = sin_tab[tw];
                end
                else
                begin
                    c = -cos_tab[DEPTH/2 - tw];
                    s = sin_tab[DEPTH/2 - tw];
                end
                for (int l = 0; l < half; l++)
                begin
                    i1 = (j << k) + l;
                    i2 = i1 + half;
                    s1 = j * half + l;
                    s2 = s1 + npts / 2;
                    ar = bank[src][s1].re;
                    ai = bank[src][s1].im;
                    br = bank[src][s2].re;
                    bi = bank[src][s2].im;
                    dr = ar - br;
                    di = ai - bi;
                    bank[dst][i1].re = clip28(ar + br);
                    bank[dst][i1].im = clip28(ai + bi);
                    bank[dst][i2].re = clip28(round_frac(dr * c + di * s));
                    bank[dst][i2].im = clip28(round_frac(di * c - dr * s));
                end
            end
            src = 1 - src;
            dst = 1 - dst;
        end
        if (inv)
        begin
            for (int i = 0; i < npts; i++)
            begin
                bank[src][i].re = clip28(bank[src][i].re >>> n_log);
                bank[src][i].im = clip28((-bank[src][i].im) >>> n_log);
            end
        end
        out_bank = src;
    endtask

    task automatic predict_word(logic func, logic signed [15:0] sre, logic signed [15:0] sim);
        bin_word_t w;
        int npts;
        npts = 1 << n_log;
        w.re = '0;
        w.im = '0;
        w.last = 1'b0;
        w.status = STATUS_SEQ;
        if (!reading && func == 1'b0)
        begin
            bank[0][loaded].re = sre;
            bank[0][loaded].im = inv ? -longint'(sim) : longint'(sim);
            loaded++;
            if (loaded >= npts)
            begin
                run_stages();
                reading = 1'b1;
                readout = 0;
            end
            w.status = STATUS_LOADED;
        end
        else if (reading && func == 1'b1)
        begin
            w.re = DATA_W'(bank[out_bank][readout].re);
            w.im = DATA_W'(bank[out_bank][readout].im);
            w.last = (readout + 1 >= npts);
            w.status = STATUS_BIN;
            readout++;
            if (readout >= npts)
            begin
                reading = 1'b0;
                loaded = 0;
                readout = 0;
            end
        end
        bins_due.push_back(w);
    endtask

    task automatic compare_word();
        bin_word_t w;
        if (bins_due.size() == 0)
        begin
            $error("unexpected result word status=%0d", out_ch.status);
            fails++;
            return;
        end
        w = bins_due.pop_front();
        if (out_ch.result_re !== w.re)
        begin
            $error("result_re expected %0d actual %0d", w.re, out_ch.result_re);
            fails++;
        end
        if (out_ch.result_im !== w.im)
        begin
            $error("result_im expected %0d actual %0d", w.im, out_ch.result_im);
            fails++;
        end
        if (out_ch.last !== w.last)
        begin
            $error("last expected %0d actual %0d", w.last, out_ch.last);
            fails++;
        end
        if (out_ch.status !== w.status)
        begin
            $error("status expected %0d actual %0d", w.status, out_ch.status);
            fails++;
        end
    endtask

    initial
    begin
        fails = 0;
        n_log = LOG2_MAX_POINTS;
        inv = 1'b0;
        loaded = 0;
        readout = 0;
        reading = 1'b0;
        out_bank = 0;
        make_twiddles();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_LOG2_POINTS || cfg_ch.index == CFG_INVERSE_MODE)
                begin
                    if (cfg_ch.index == CFG_LOG2_POINTS)
                        n_log = (cfg_ch.data < 1) ? 1 :
                                (cfg_ch.data > LOG2_MAX_POINTS) ? LOG2_MAX_POINTS : cfg_ch.data;
                    else
                        inv = cfg_ch.data[0];
                    loaded = 0;
                    readout = 0;
                    reading = 1'b0;
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_word(in_ch.func, in_ch.sample_re, in_ch.sample_im);
            if (out_ch.valid && out_ch.ready)
                compare_word();
        end
        pending = bins_due.size();
    end

    initial pending = 0;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives sample loads, bin reads and register writes into the transform
// block under several idle and stall patterns, including one long output
// hold, and reports the verdict from the checker's failure count or a timeout.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fftr2_pkg::*;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   sent;
    int   idle_pct;
    int   stall_pct;
    bit   hold_req;
    int   cur_n;
    int   settle;

    fftr2_in_if  in_ch ();
    fftr2_out_if out_ch ();
    fftr2_cfg_if cfg_ch ();

    fft_radix2_dif_autosort_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    fftr2_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch),
        .fails   (fails),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic set_mode();
        case ((sent / 150) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 15; stall_pct = 15; end
        endcase
    endtask

    task automatic send(logic func, logic [15:0] sre, logic [15:0] sim);
        set_mode();
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= func;
        in_ch.sample_re <= sre;
        in_ch.sample_im <= sim;
        do
            @(negedge clk);
        while (!in_ch.ready);
        @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
        settle = 20;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_LOG2_POINTS)
            cur_n = (val < 1) ? 1 : (val > LOG2_MAX_POINTS) ? LOG2_MAX_POINTS : val;
    endtask

    task automatic run_transform(bit noisy);
        int npts;
        npts = 1 << cur_n;
        for (int i = 0; i < npts; i++)
        begin
            if (noisy && $urandom_range(99) < 5)
                send(1'b1, pick_sample(), pick_sample());
            if (noisy && $urandom_range(99) < 2)
                return;
            send(1'b0, pick_sample(), pick_sample());
        end
        settle = (npts / 2) * cur_n * 9 + 50;
        for (int i = 0; i < npts; i++)
        begin
            if (noisy && $urandom_range(99) < 5)
                send(1'b0, pick_sample(), pick_sample());
            send(1'b1, pick_sample(), pick_sample());
        end
        settle = 20;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        int r;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.sample_re = '0;
        in_ch.sample_im = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        cur_n = LOG2_MAX_POINTS;
        settle = 20;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(1'b1, 16'h7FFF, 16'h8000);
        send(1'b0, 16'h8000, 16'h7FFF);
        write_reg(CFG_LOG2_POINTS, 4'd1);
        send(1'b0, 16'h7FFF, 16'h8000);
        send(1'b0, 16'h8000, 16'h7FFF);
        settle = 100;
        send(1'b0, 16'h1234, 16'h4321);
        send(1'b1, 16'h0000, 16'h0000);
        send(1'b1, 16'h0000, 16'h0000);
        send(1'b1, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_LOG2_POINTS, 4'd0);
        write_reg(CFG_INVERSE_MODE, 4'd1);
        run_transform(1'b0);
        write_reg(CFG_INVERSE_MODE, 4'd0);
        write_reg(CFG_LOG2_POINTS, 4'd15);
        write_reg(2'd2, 4'hF);
        write_reg(2'd3, 4'hA);
        hold_req = 1'b1;
        run_transform(1'b0);
        write_reg(CFG_INVERSE_MODE, 4'hF);
        write_reg(CFG_LOG2_POINTS, 4'd3);
        run_transform(1'b0);

        while (sent < 2200)
        begin
            r = $urandom_range(99);
            if (r < 3)
                write_reg(CFG_LOG2_POINTS, 4'($urandom_range(8, 15)));
            else if (r < 8)
                write_reg(CFG_LOG2_POINTS, 4'd0);
            else
                write_reg(CFG_LOG2_POINTS, 4'($urandom_range(1, 4)));
            write_reg(CFG_INVERSE_MODE, 4'($urandom));
            if (sent > 600 && !hold_req && sent < 700)
                hold_req = 1'b1;
            run_transform(1'b1);
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("fft_radix2_dif_autosort_top verification clean");
        else
            $display("fft_radix2_dif_autosort_top verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("fft_radix2_dif_autosort_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fftr2_pkg.sv
rtl/fftr2_if.sv
rtl/fftr2_bank.sv
rtl/fft_radix2_dif_autosort_top.sv
sim/fftr2_checker.sv
sim/testbench.sv
